FILE: rtl/skn_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the skin mask centroid block.
// No dependencies; the top level, front end, back end and checker refer to it by scoped names.
package skn_pkg;

  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 12;
  localparam int COORD_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [SIZE_W-1:0]  size_t;
  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_LEFT_LIMIT   = 3'd2,
    REG_RIGHT_LIMIT  = 3'd3,
    REG_TOP_LIMIT    = 3'd4,
    REG_BOTTOM_LIMIT = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    DIR_LEFT   = 3'd0,
    DIR_RIGHT  = 3'd1,
    DIR_TOP    = 3'd2,
    DIR_BOTTOM = 3'd3,
    DIR_CENTER = 3'd4,
    DIR_NONE   = 3'd5
  } dir_e;

  typedef enum logic {
    KIND_MASK    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  localparam pix_t RED_MIN     = 8'd95;
  localparam pix_t GREEN_MIN   = 8'd40;
  localparam pix_t BLUE_MIN    = 8'd20;
  localparam pix_t RG_DIFF_MIN = 8'd15;

  localparam size_t  FRAME_WIDTH_RST  = 12'd1920;
  localparam size_t  FRAME_HEIGHT_RST = 12'd1080;
  localparam coord_t LEFT_LIMIT_RST   = 11'd640;
  localparam coord_t RIGHT_LIMIT_RST  = 11'd1280;
  localparam coord_t TOP_LIMIT_RST    = 11'd360;
  localparam coord_t BOTTOM_LIMIT_RST = 11'd720;

  typedef struct packed {
    size_t  frame_width;
    size_t  frame_height;
    coord_t left_limit;
    coord_t right_limit;
    coord_t top_limit;
    coord_t bottom_limit;
  } cfg_t;

endpackage

FILE: rtl/skin_mask_centroid_direction.sv
`timescale 1ns / 1ps
// Top level: configuration registers, front end, request queue, back end.
// Depends on skn_pkg, skn_front, skn_fifo, skn_back.
//
//   channel  | signals                                  | handshake
//   ---------+------------------------------------------+-------------------
//   pixel in | green_in_i, blue_in_i, red_in_i          | in_valid_i/in_ready_o
//   result   | kind_o, skin_mask_o, hand_x_o, hand_y_o, | out_valid_o/out_ready_i
//            | direction_o, last_o                      |
//   config   | cfg_idx_i, cfg_data_i                    | cfg_we_i, no wait
//
// One pixel per cycle while the queue has room; each mask result is written to the queue
// and then registered at the output. End of frame: the summary is registered once both
// dividers are done and the last mask result is taken; the 4-entry queue takes four
// pixels, then in_ready_o stays low until the summary is loaded.
// Reset clears position, sums, queue and restores the register defaults.
// Output stalls back up through the queue to in_ready_o.
module skin_mask_centroid_direction #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [skn_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [skn_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       green_in_i,
  input  logic [7:0]                       blue_in_i,
  input  logic [7:0]                       red_in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             kind_o,
  output logic                             skin_mask_o,
  output logic [10:0]                      hand_x_o,
  output logic [10:0]                      hand_y_o,
  output logic [2:0]                       direction_o,
  output logic                             last_o
);

  localparam int NW  = $clog2(64'(MAX_WIDTH) * 64'(MAX_HEIGHT) + 64'd1);
  localparam int SXW = $clog2(64'(MAX_HEIGHT) * 64'(MAX_WIDTH) * 64'(MAX_WIDTH - 1) / 64'd2
                              + 64'd1);
  localparam int SYW = $clog2(64'(MAX_WIDTH) * 64'(MAX_HEIGHT) * 64'(MAX_HEIGHT - 1) / 64'd2
                              + 64'd1);
  localparam int ENTRY_W = 2 + SXW + SYW + NW;
  localparam int QDEPTH  = 4;

  skn_pkg::cfg_t    cfg_q;
  logic             push, pop, full, empty;
  logic             f_eof, f_skin, b_eof, b_skin;
  logic [SXW-1:0]   f_sum_x, b_sum_x;
  logic [SYW-1:0]   f_sum_y, b_sum_y;
  logic [NW-1:0]    f_count, b_count;
  logic [ENTRY_W-1:0] q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= skn_pkg::FRAME_WIDTH_RST;
      cfg_q.frame_height <= skn_pkg::FRAME_HEIGHT_RST;
      cfg_q.left_limit   <= skn_pkg::LEFT_LIMIT_RST;
      cfg_q.right_limit  <= skn_pkg::RIGHT_LIMIT_RST;
      cfg_q.top_limit    <= skn_pkg::TOP_LIMIT_RST;
      cfg_q.bottom_limit <= skn_pkg::BOTTOM_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        skn_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i;
        skn_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i;
        skn_pkg::REG_LEFT_LIMIT:   cfg_q.left_limit   <= skn_pkg::coord_t'(cfg_data_i);
        skn_pkg::REG_RIGHT_LIMIT:  cfg_q.right_limit  <= skn_pkg::coord_t'(cfg_data_i);
        skn_pkg::REG_TOP_LIMIT:    cfg_q.top_limit    <= skn_pkg::coord_t'(cfg_data_i);
        skn_pkg::REG_BOTTOM_LIMIT: cfg_q.bottom_limit <= skn_pkg::coord_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  skn_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .green_i    (green_in_i),
    .blue_i     (blue_in_i),
    .red_i      (red_in_i),
    .cfg_i      (cfg_q),
    .full_i     (full),
    .push_o     (push),
    .eof_o      (f_eof),
    .skin_o     (f_skin),
    .sum_x_o    (f_sum_x),
    .sum_y_o    (f_sum_y),
    .count_o    (f_count)
  );

  assign q_in = {f_eof, f_skin, f_sum_x, f_sum_y, f_count};

  skn_fifo #(.WIDTH(ENTRY_W), .DEPTH(QDEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .pop_i   (pop),
    .data_o  (q_out),
    .full_o  (full),
    .empty_o (empty)
  );

  assign {b_eof, b_skin, b_sum_x, b_sum_y, b_count} = q_out;

  skn_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .eof_i       (b_eof),
    .skin_i      (b_skin),
    .sum_x_i     (b_sum_x),
    .sum_y_i     (b_sum_y),
    .count_i     (b_count),
    .pop_o       (pop),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .skin_mask_o (skin_mask_o),
    .hand_x_o    (hand_x_o),
    .hand_y_o    (hand_y_o),
    .direction_o (direction_o),
    .last_o      (last_o)
  );

endmodule

FILE: rtl/skn_front.sv
`timescale 1ns / 1ps
// Front end: accepts pixels, classifies skin, tracks raster position and sums.
// Depends on skn_pkg; pushes one request per pixel into the queue.
module skn_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int RW  = $clog2(MAX_HEIGHT),
  localparam int NW  = $clog2(64'(MAX_WIDTH) * 64'(MAX_HEIGHT) + 64'd1),
  localparam int SXW = $clog2(64'(MAX_HEIGHT) * 64'(MAX_WIDTH) * 64'(MAX_WIDTH - 1) / 64'd2
                              + 64'd1),
  localparam int SYW = $clog2(64'(MAX_WIDTH) * 64'(MAX_HEIGHT) * 64'(MAX_HEIGHT - 1) / 64'd2
                              + 64'd1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  skn_pkg::pix_t      green_i,
  input  skn_pkg::pix_t      blue_i,
  input  skn_pkg::pix_t      red_i,
  input  skn_pkg::cfg_t      cfg_i,
  input  logic               full_i,
  output logic               push_o,
  output logic               eof_o,
  output logic               skin_o,
  output logic [SXW-1:0]     sum_x_o,
  output logic [SYW-1:0]     sum_y_o,
  output logic [NW-1:0]      count_o
);

  localparam int XEW = (CW + 1 > skn_pkg::SIZE_W) ? CW + 1 : skn_pkg::SIZE_W;
  localparam int YEW = (RW + 1 > skn_pkg::SIZE_W) ? RW + 1 : skn_pkg::SIZE_W;

  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [SXW-1:0] sum_x_q, sum_x_d, sum_x_add;
  logic [SYW-1:0] sum_y_q, sum_y_d, sum_y_add;
  logic [NW-1:0]  cnt_q, cnt_d, cnt_add;
  logic           skin, end_line, end_frame;

  always_comb begin
    skin = (red_i > skn_pkg::RED_MIN) && (green_i > skn_pkg::GREEN_MIN) &&
           (blue_i > skn_pkg::BLUE_MIN) && (red_i > blue_i) && (red_i > green_i) &&
           ((red_i - green_i) > skn_pkg::RG_DIFF_MIN);
    end_line  = ((XEW'(col_q) + XEW'(1)) >= XEW'(cfg_i.frame_width)) ||
                (col_q == CW'(MAX_WIDTH - 1));
    end_frame = end_line &&
                (((YEW'(row_q) + YEW'(1)) >= YEW'(cfg_i.frame_height)) ||
                 (row_q == RW'(MAX_HEIGHT - 1)));

    sum_x_add = skin ? sum_x_q + SXW'(col_q) : sum_x_q;
    sum_y_add = skin ? sum_y_q + SYW'(row_q) : sum_y_q;
    cnt_add   = skin ? cnt_q + NW'(1) : cnt_q;

    in_ready_o = !full_i;
    push_o     = in_valid_i && !full_i;

    col_d   = col_q;
    row_d   = row_q;
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    cnt_d   = cnt_q;
    if (push_o) begin
      if (end_frame) begin
        col_d   = '0;
        row_d   = '0;
        sum_x_d = '0;
        sum_y_d = '0;
        cnt_d   = '0;
      end else begin
        if (end_line) begin
          col_d = '0;
          row_d = row_q + RW'(1);
        end else begin
          col_d = col_q + CW'(1);
        end
        sum_x_d = sum_x_add;
        sum_y_d = sum_y_add;
        cnt_d   = cnt_add;
      end
    end

    eof_o   = end_frame;
    skin_o  = skin;
    sum_x_o = sum_x_add;
    sum_y_o = sum_y_add;
    count_o = cnt_add;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
      cnt_q   <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: rtl/skn_fifo.sv
`timescale 1ns / 1ps
// Short request queue between front and back ends, flop based.
// No package dependencies.
module skn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CNTW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNTW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/skn_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, quotient known to fit QUO_W bits.
// No package dependencies.
module skn_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 23,
  parameter int QUO_W = 11,
  localparam int SH_W  = DEN_W + QUO_W - 1,
  localparam int CMP_W = (NUM_W > SH_W) ? NUM_W : SH_W,
  localparam int CNT_W = $clog2(QUO_W + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);

  logic [NUM_W-1:0] rem_q, rem_d;
  logic [SH_W-1:0]  den_q, den_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             fits;
  logic [CMP_W-1:0] diff;

  always_comb begin
    fits  = CMP_W'(rem_q) >= CMP_W'(den_q);
    diff  = CMP_W'(rem_q) - CMP_W'(den_q);
    rem_d = rem_q;
    den_d = den_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = num_i;
      den_d = SH_W'(den_i) << (QUO_W - 1);
      quo_d = '0;
      cnt_d = CNT_W'(QUO_W);
    end else if (cnt_q != '0) begin
      rem_d = fits ? NUM_W'(diff) : rem_q;
      den_d = den_q >> 1;
      quo_d = {quo_q[QUO_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  assign done_o = (cnt_q == '0);
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

endmodule

FILE: rtl/skn_back.sv
`timescale 1ns / 1ps
// Back end: drains the queue, emits mask results, divides sums at end of frame.
// Depends on skn_pkg and skn_div.
module skn_back #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int RW  = $clog2(MAX_HEIGHT),
  localparam int NW  = $clog2(64'(MAX_WIDTH) * 64'(MAX_HEIGHT) + 64'd1),
  localparam int SXW = $clog2(64'(MAX_HEIGHT) * 64'(MAX_WIDTH) * 64'(MAX_WIDTH - 1) / 64'd2
                              + 64'd1),
  localparam int SYW = $clog2(64'(MAX_WIDTH) * 64'(MAX_HEIGHT) * 64'(MAX_HEIGHT - 1) / 64'd2
                              + 64'd1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  logic               eof_i,
  input  logic               skin_i,
  input  logic [SXW-1:0]     sum_x_i,
  input  logic [SYW-1:0]     sum_y_i,
  input  logic [NW-1:0]      count_i,
  output logic               pop_o,
  input  skn_pkg::cfg_t      cfg_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic               skin_mask_o,
  output skn_pkg::coord_t    hand_x_o,
  output skn_pkg::coord_t    hand_y_o,
  output logic [2:0]         direction_o,
  output logic               last_o
);

  typedef enum logic {
    ST_PIXEL,
    ST_DIVIDE
  } state_e;

  state_e                state_q;
  logic                  out_valid_q;
  skn_pkg::kind_e        kind_q;
  logic                  skin_q, last_q, zero_q;
  skn_pkg::coord_t       x_q, y_q;
  skn_pkg::dir_e         dir_q;

  logic                  load_ok, start, sum_ready, done_x, done_y, fx, fy;
  logic [CW-1:0]         quo_x;
  logic [RW-1:0]         quo_y;
  skn_pkg::coord_t       cx, cy;
  skn_pkg::dir_e         dir;

  skn_div #(.NUM_W(SXW), .DEN_W(NW), .QUO_W(CW)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .num_i   (sum_x_i),
    .den_i   (count_i),
    .done_o  (done_x),
    .quo_o   (quo_x)
  );

  skn_div #(.NUM_W(SYW), .DEN_W(NW), .QUO_W(RW)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .num_i   (sum_y_i),
    .den_i   (count_i),
    .done_o  (done_y),
    .quo_o   (quo_y)
  );

  always_comb begin
    load_ok   = !out_valid_q || out_ready_i;
    pop_o     = (state_q == ST_PIXEL) && !empty_i && load_ok;
    start     = pop_o && eof_i;
    sum_ready = (state_q == ST_DIVIDE) && done_x && done_y && load_ok;

    cx = zero_q ? '0 : skn_pkg::coord_t'(quo_x);
    cy = zero_q ? '0 : skn_pkg::coord_t'(quo_y);
    fy = (cy > cfg_i.top_limit) && (cy < cfg_i.bottom_limit);
    fx = (cx > cfg_i.left_limit) && (cx < cfg_i.right_limit);
    if (zero_q) begin
      dir = skn_pkg::DIR_NONE;
    end else if (cx < cfg_i.left_limit) begin
      dir = fy ? skn_pkg::DIR_LEFT : skn_pkg::DIR_NONE;
    end else if (cx > cfg_i.right_limit) begin
      dir = fy ? skn_pkg::DIR_RIGHT : skn_pkg::DIR_NONE;
    end else if (cy < cfg_i.top_limit) begin
      dir = fx ? skn_pkg::DIR_TOP : skn_pkg::DIR_NONE;
    end else if (cy > cfg_i.bottom_limit) begin
      dir = fx ? skn_pkg::DIR_BOTTOM : skn_pkg::DIR_NONE;
    end else begin
      dir = (fx && fy) ? skn_pkg::DIR_CENTER : skn_pkg::DIR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_PIXEL;
      out_valid_q <= 1'b0;
      kind_q      <= skn_pkg::KIND_MASK;
      skin_q      <= 1'b0;
      last_q      <= 1'b0;
      zero_q      <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      dir_q       <= skn_pkg::DIR_LEFT;
    end else begin
      case (state_q)
        ST_PIXEL: begin
          if (pop_o) begin
            out_valid_q <= 1'b1;
            kind_q      <= skn_pkg::KIND_MASK;
            skin_q      <= skin_i;
            last_q      <= !eof_i;
            x_q         <= '0;
            y_q         <= '0;
            dir_q       <= skn_pkg::DIR_LEFT;
            if (eof_i) begin
              zero_q  <= (count_i == '0);
              state_q <= ST_DIVIDE;
            end
          end else if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_DIVIDE: begin
          if (sum_ready) begin
            out_valid_q <= 1'b1;
            kind_q      <= skn_pkg::KIND_SUMMARY;
            skin_q      <= 1'b0;
            last_q      <= 1'b1;
            x_q         <= cx;
            y_q         <= cy;
            dir_q       <= dir;
            state_q     <= ST_PIXEL;
          end else if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= ST_PIXEL;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign skin_mask_o = skin_q;
  assign hand_x_o    = x_q;
  assign hand_y_o    = y_q;
  assign direction_o = dir_q;
  assign last_o      = last_q;

endmodule

FILE: rtl/skn_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the result channel, bound to the top level.
// Depends on skn_pkg.
module skn_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        kind_o,
  input logic        skin_mask_o,
  input logic [10:0] hand_x_o,
  input logic [10:0] hand_y_o,
  input logic [2:0]  direction_o,
  input logic        last_o
);

  logic pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      if (kind_o == skn_pkg::KIND_SUMMARY) begin
        pend_q <= 1'b0;
      end else if (!last_o) begin
        pend_q <= 1'b1;
      end
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
      $stable(skin_mask_o) && $stable(hand_x_o) && $stable(hand_y_o) &&
      $stable(direction_o) && $stable(last_o))
    else $error("result changed while stalled");

  a_summary_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == skn_pkg::KIND_SUMMARY) |-> last_o && !skin_mask_o)
    else $error("summary result malformed");

  a_mask_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == skn_pkg::KIND_MASK) |->
      (hand_x_o == '0) && (hand_y_o == '0) && (direction_o == skn_pkg::DIR_LEFT))
    else $error("mask result carries summary fields");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == skn_pkg::KIND_SUMMARY) == pend_q))
    else $error("summary out of order");

endmodule

bind skin_mask_centroid_direction skn_chk u_chk (.*);

FILE: tb/sv/skin_mask_centroid_direction_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for skin_mask_centroid_direction: pixel frames with random
// pacing on both channels, checked against a built-in centroid and direction predictor.
// Depends on skn_pkg and the skin_mask_centroid_direction RTL.
module skin_mask_centroid_direction_tb;
  import skn_pkg::*;

  localparam int MAX_W      = 2048;
  localparam int MAX_H      = 2048;
  localparam int SETTLE     = 24;
  localparam int LIMIT      = 400000;
  localparam int RAND_ITEMS = 680;

  typedef struct {
    kind_e  kind;
    logic   skin;
    coord_t x;
    coord_t y;
    dir_e   dir;
    logic   last;
  } result_t;

  class centroid_scoreboard;
    size_t           width, height;
    coord_t          left, right, top, bottom;
    int unsigned     col, row;
    longint unsigned sum_x, sum_y, skin_n;
    result_t         pending_results[$];
    int unsigned     errors, pixels, frames, skin_frames;
    int unsigned     dir_seen[6];

    function new();
      width  = FRAME_WIDTH_RST;
      height = FRAME_HEIGHT_RST;
      left   = LEFT_LIMIT_RST;
      right  = RIGHT_LIMIT_RST;
      top    = TOP_LIMIT_RST;
      bottom = BOTTOM_LIMIT_RST;
    endfunction

    function void write_reg(reg_idx_e idx, logic [11:0] data);
      case (idx)
        REG_FRAME_WIDTH:  width  = data;
        REG_FRAME_HEIGHT: height = data;
        REG_LEFT_LIMIT:   left   = data[10:0];
        REG_RIGHT_LIMIT:  right  = data[10:0];
        REG_TOP_LIMIT:    top    = data[10:0];
        REG_BOTTOM_LIMIT: bottom = data[10:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_size(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function dir_e steer(int unsigned x, int unsigned y);
      bit fx, fy;
      fy = (y > top) && (y < bottom);
      fx = (x > left) && (x < right);
      if (x < left) return fy ? DIR_LEFT : DIR_NONE;
      if (x > right) return fy ? DIR_RIGHT : DIR_NONE;
      if (y < top) return fx ? DIR_TOP : DIR_NONE;
      if (y > bottom) return fx ? DIR_BOTTOM : DIR_NONE;
      return (fx && fy) ? DIR_CENTER : DIR_NONE;
    endfunction

    function void note_pixel(pix_t red, pix_t green, pix_t blue);
      int unsigned w, h, r, g, b;
      bit          skin, eol, eof;
      result_t     res;
      w = eff_size(width, MAX_W);
      h = eff_size(height, MAX_H);
      r = red;
      g = green;
      b = blue;
      skin = r > 95 && g > 40 && b > 20 && r > b && r > g && (r - g) > 15;
      eol = (col + 1) >= w;
      eof = eol && (row + 1) >= h;
      pixels++;
      if (skin) begin
        sum_x += col;
        sum_y += row;
        skin_n++;
      end
      res.kind = KIND_MASK;
      res.skin = skin;
      res.x    = '0;
      res.y    = '0;
      res.dir  = DIR_LEFT;
      res.last = !eof;
      pending_results.push_back(res);
      if (!eof) begin
        if (eol) begin
          col = 0;
          row++;
        end else begin
          col++;
        end
        return;
      end
      res.kind = KIND_SUMMARY;
      res.skin = 1'b0;
      res.dir  = DIR_NONE;
      if (skin_n != 0) begin
        res.x   = coord_t'(sum_x / skin_n);
        res.y   = coord_t'(sum_y / skin_n);
        res.dir = steer(res.x, res.y);
        skin_frames++;
      end
      res.last = 1'b1;
      pending_results.push_back(res);
      dir_seen[res.dir]++;
      frames++;
      col    = 0;
      row    = 0;
      sum_x  = 0;
      sum_y  = 0;
      skin_n = 0;
    endfunction

    function void field_ok(string what, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d", $time, got.kind);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      field_ok("kind", want.kind, got.kind);
      field_ok("skin_mask", want.skin, got.skin);
      field_ok("hand_x", want.x, got.x);
      field_ok("hand_y", want.y, got.y);
      field_ok("direction", want.dir, got.dir);
      field_ok("last", want.last, got.last);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [7:0]            green_in_i, blue_in_i, red_in_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  kind_o, skin_mask_o, last_o;
  logic [10:0]           hand_x_o, hand_y_o;
  logic [2:0]            direction_o;

  centroid_scoreboard sb;
  bit                 calm;
  int                 rx_wait;
  int unsigned        cycles;

  skin_mask_centroid_direction #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .green_in_i (green_in_i),
    .blue_in_i  (blue_in_i),
    .red_in_i   (red_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kind_o     (kind_o),
    .skin_mask_o(skin_mask_o),
    .hand_x_o   (hand_x_o),
    .hand_y_o   (hand_y_o),
    .direction_o(direction_o),
    .last_o     (last_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  // collect results, stall between them
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_wait = 0;
    end else if (out_valid_o && out_ready_i) begin
      got.kind = kind_e'(kind_o);
      got.skin = skin_mask_o;
      got.x    = hand_x_o;
      got.y    = hand_y_o;
      got.dir  = dir_e'(direction_o);
      got.last = last_o;
      sb.check_result(got);
      rx_wait = draw_wait();
      out_ready_i <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready_i <= (rx_wait == 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("skin_mask_centroid_direction_tb failed");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [11:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(pix_t red, pix_t green, pix_t blue);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_in_i   <= red;
    green_in_i <= green;
    blue_in_i  <= blue;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_pixel(red, green, blue);
  endtask

  // drop the request, hold until every result is back, then let the dividers settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic send_pixels(int n, int skin_pct);
    pix_t r, g, b;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1, 100) <= skin_pct) begin
        r = $urandom_range(96, 255);
        g = $urandom_range(41, r - 16);
        b = $urandom_range(21, r - 1);
      end else begin
        r = $urandom_range(0, 255);
        g = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
      end
      send_pixel(r, g, b);
    end
  endtask

  function automatic logic [11:0] pick_border(int span);
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'd2047;
      2: return 12'hFFF;
      default: return $urandom_range(0, span);
    endcase
  endfunction

  task automatic random_phase();
    int w, h, area, n;
    w = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
    h = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
    area = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
    write_reg(REG_FRAME_WIDTH, 12'(w));
    write_reg(REG_FRAME_HEIGHT, 12'(h));
    if ($urandom_range(0, 3) != 0) write_reg(REG_LEFT_LIMIT, pick_border(w));
    if ($urandom_range(0, 3) != 0) write_reg(REG_RIGHT_LIMIT, pick_border(w));
    if ($urandom_range(0, 3) != 0) write_reg(REG_TOP_LIMIT, pick_border(h));
    if ($urandom_range(0, 3) != 0) write_reg(REG_BOTTOM_LIMIT, pick_border(h));
    calm = ($urandom_range(0, 4) == 0);
    n = $urandom_range(1, 3);
    for (int f = 0; f < n; f++) begin
      case ($urandom_range(0, 3))
        0: send_pixels(area, 0);
        1: send_pixels(area, 25);
        2: send_pixels(area, 60);
        default: send_pixels(area, 95);
      endcase
    end
    // leave a partial frame so the next sizes may cut it short
    if ($urandom_range(0, 1) == 0) send_pixels($urandom_range(0, area - 1), 50);
    wait_idle();
  endtask

  initial begin
    int start_px;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_FRAME_WIDTH;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    green_in_i  <= '0;
    blue_in_i   <= '0;
    red_in_i    <= '0;
    calm = 1'b0;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // thresholds, starting under the reset sizes
    send_pixel(0, 0, 0);
    send_pixel(255, 255, 255);
    send_pixel(96, 41, 21);
    send_pixel(95, 41, 21);
    wait_idle();
    // zero width counts as one; column already past it ends the line at once
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 3);
    send_pixel(96, 40, 21);
    send_pixel(96, 41, 20);
    send_pixel(200, 100, 200);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 0);
    send_pixel(200, 200, 100);
    send_pixel(200, 185, 100);
    send_pixel(200, 184, 100);
    wait_idle();
    // borders out of order; first frame has no skin at all
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_FRAME_HEIGHT, 2);
    write_reg(REG_LEFT_LIMIT, 2047);
    write_reg(REG_RIGHT_LIMIT, 0);
    write_reg(REG_TOP_LIMIT, 2047);
    write_reg(REG_BOTTOM_LIMIT, 0);
    send_pixel(10, 200, 30);
    send_pixel(255, 0, 255);
    send_pixel(120, 110, 50);
    send_pixel(0, 255, 0);
    wait_idle();
    write_reg(REG_FRAME_HEIGHT, 1);
    send_pixel(255, 239, 254);
    send_pixel(255, 239, 254);
    wait_idle();

    start_px = sb.pixels;
    while (sb.pixels < start_px + RAND_ITEMS) random_phase();
    wait_idle();

    $display("run covered %0d pixels and %0d frames, %0d of them with skin",
             sb.pixels, sb.frames, sb.skin_frames);
    $display("directions left/right/top/bottom/center/none: %0d/%0d/%0d/%0d/%0d/%0d",
             sb.dir_seen[0], sb.dir_seen[1], sb.dir_seen[2], sb.dir_seen[3],
             sb.dir_seen[4], sb.dir_seen[5]);
    if (sb.errors == 0) begin
      $display("skin_mask_centroid_direction_tb passed");
    end else begin
      $display("skin_mask_centroid_direction_tb failed");
    end
    $finish;
  end

endmodule
